// ===== src/pmc_pkg.sv =====
// shared types and constants for the point morton code generator
`timescale 1ns / 1ps
package pmc_pkg;

	localparam int AXES       = 3;
	localparam int LEVEL_BITS = 10;
	localparam int COORD_W    = 32;
	localparam int MORTON_W   = 30;
	localparam int FULL_W     = AXES * LEVEL_BITS;
	localparam int REM_W      = COORD_W + 1;
	localparam int IN_W       = ((AXES * COORD_W + 7) / 8) * 8;
	localparam int OUT_W      = ((MORTON_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;

	// s1 subtract, s2 range check, one stage per quotient bit, output register
	localparam int NSTG = LEVEL_BITS + 3;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_Z = 3'd5;

	typedef struct packed {
		logic [REM_W-1:0]      rem;
		logic [COORD_W-1:0]    span;
		logic [LEVEL_BITS-1:0] q;
		logic                  sat;
		logic                  neg;
		logic                  degen;
	} lane_t;

endpackage

// ===== src/pmc_div_step.sv =====
// one restoring division step: produces one quotient bit per stage
`timescale 1ns / 1ps
module pmc_div_step import pmc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  lane_t din,
	output lane_t dout
);

	logic [REM_W-1:0] r2;
	logic [REM_W-1:0] dv;
	logic             ge;
	lane_t            nxt;

	always_comb begin
		r2  = {din.rem[REM_W-2:0], 1'b0};
		dv  = {1'b0, din.span};
		ge  = (r2 >= dv);
		nxt = din;
		nxt.rem = ge ? (r2 - dv) : r2;
		nxt.q   = LEVEL_BITS'({din.q, ge});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== src/pmc_lane.sv =====
// per-axis quantizer lane: offset, range check and pipelined divide
`timescale 1ns / 1ps
module pmc_lane import pmc_pkg::*; (
	input  logic                      clk,
	input  logic [NSTG-1:0]           en,
	input  logic signed [COORD_W-1:0] coord,
	input  logic signed [COORD_W-1:0] low,
	input  logic signed [COORD_W-1:0] top,
	output lane_t                     res
);

	logic signed [COORD_W:0] d_s1;
	logic signed [COORD_W:0] span_s1;
	lane_t                   init;
	lane_t                   chain [LEVEL_BITS+1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s1    <= {coord[COORD_W-1], coord} - {low[COORD_W-1], low};
			span_s1 <= {top[COORD_W-1], top} - {low[COORD_W-1], low};
		end
	end

	always_comb begin
		init.rem   = {1'b0, d_s1[COORD_W-1:0]};
		init.span  = span_s1[COORD_W-1:0];
		init.q     = '0;
		init.neg   = d_s1[COORD_W];
		init.degen = span_s1[COORD_W] || (span_s1 == '0);
		// offset at or past the span means the cell would reach 1 << LEVEL_BITS
		init.sat   = !d_s1[COORD_W] && (d_s1[COORD_W-1:0] >= span_s1[COORD_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			chain[0] <= init;
		end
	end

	for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_step
		pmc_div_step u_step (
			.clk  (clk),
			.en   (en[k+2]),
			.din  (chain[k]),
			.dout (chain[k+1])
		);
	end

	assign res = chain[LEVEL_BITS];

endmodule

// ===== src/pmc_merge.sv =====
// merges lane cells: clamping, bit interleave and output register
`timescale 1ns / 1ps
module pmc_merge import pmc_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  lane_t               lanes [AXES],
	output logic [MORTON_W-1:0] morton_code,
	output logic                clamped
);

	logic [LEVEL_BITS-1:0] grid [AXES];
	logic [FULL_W-1:0]     full;
	logic                  any_degen;
	logic                  any_clip;

	always_comb begin
		any_degen = 1'b0;
		any_clip  = 1'b0;
		full      = '0;
		for (int a = 0; a < AXES; a++) begin
			if (lanes[a].neg) begin
				grid[a] = '0;
			end else if (lanes[a].sat) begin
				grid[a] = '1;
			end else begin
				grid[a] = lanes[a].q;
			end
			any_degen = any_degen | lanes[a].degen;
			any_clip  = any_clip | lanes[a].neg | lanes[a].sat;
		end
		// first axis holds the upper bit of each group
		for (int h = 0; h < LEVEL_BITS; h++) begin
			for (int a = 0; a < AXES; a++) begin
				full[h*AXES + (AXES-1-a)] = grid[a][h];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			morton_code <= any_degen ? '0 : MORTON_W'(full);
			clamped     <= any_degen | any_clip;
		end
	end

endmodule

// ===== src/point_morton_code_generator.sv =====
// top level of the point morton code generator
`timescale 1ns / 1ps
// Takes one point per cycle and returns its 30-bit Morton code: each axis has
// its own lane with an offset stage, a range check stage and a restoring divider
// that yields one cell bit per stage, and a merge stage interleaves the three
// cells into the output register. A stalled output only holds back the stages
// behind it up to the first empty one, so the sustained rate is one point per
// cycle whenever the output is taken. The user must write the box registers
// through the plain write port only while no point is in flight; the block
// does not enforce this. A box with top at or below low on any axis gives code
// 0 with clamped set, and a point outside the box is clamped to the nearest cell.
module point_morton_code_generator import pmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // coord_x, coord_y, coord_z
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,  // morton_code, zero fill
	output logic                 m_tuser   // clamped
);

	logic signed [COORD_W-1:0] low_q [AXES];
	logic signed [COORD_W-1:0] top_q [AXES];
	logic [NSTG-1:0]           valid_q;
	logic [NSTG-1:0]           en;
	lane_t                     lanes [AXES];
	logic [MORTON_W-1:0]       morton_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				low_q[a] <= '0;
				top_q[a] <= COORD_W'(1 << LEVEL_BITS);
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_X: low_q[0] <= cfg_data;
				REG_LOW_Y: low_q[1] <= cfg_data;
				REG_LOW_Z: low_q[2] <= cfg_data;
				REG_TOP_X: top_q[0] <= cfg_data;
				REG_TOP_Y: top_q[1] <= cfg_data;
				REG_TOP_Z: top_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en[NSTG-1] = !valid_q[NSTG-1] || m_tready;
		for (int i = NSTG-2; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		pmc_lane u_lane (
			.clk   (clk),
			.en    (en),
			.coord (s_tdata[a*COORD_W +: COORD_W]),
			.low   (low_q[a]),
			.top   (top_q[a]),
			.res   (lanes[a])
		);
	end

	pmc_merge u_merge (
		.clk         (clk),
		.en          (en[NSTG-1]),
		.lanes       (lanes),
		.morton_code (morton_code),
		.clamped     (m_tuser)
	);

	assign s_tready = en[0];
	assign m_tvalid = valid_q[NSTG-1];
	assign m_tdata  = OUT_W'(morton_code);

`ifndef ASSERT_OFF
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&valid_q) && !m_tready |-> !s_tready)
		else $error("request taken while every stage is full and output stalled");

	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[NSTG-1] |-> s_tready)
		else $error("input stalled although output slot is empty");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_q[0])
		else $error("accepted request did not enter the first stage");
`endif

endmodule
